// File: hdl/zip_central_directory_parser_core_macros.svh
// assertion macros of the central directory parser, used by the result queue
`ifndef ZIP_CENTRAL_DIRECTORY_PARSER_CORE_MACROS_SVH
`define ZIP_CENTRAL_DIRECTORY_PARSER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define ZCDP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("zcdp check failed");
`define ZCDP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zcdp check failed");
`define ZCDP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zcdp check failed");
`else
`define ZCDP_ASSERT(label, prop)
`define ZCDP_ASSERT_IMPL(label, ante, cons)
`define ZCDP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hdl/zcdp_pkg.sv
// types and constants of the central directory parser
package zcdp_pkg;

  localparam int POS_W = 18;

  localparam logic [1:0] KIND_NAME   = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic ERR_SIGNATURE = 1'b0;
  localparam logic ERR_NAME_LONG = 1'b1;

  localparam logic [31:0] CD_SIGNATURE = 32'h02014b50;
  localparam logic [7:0]  SLASH_BYTE   = 8'h2f;

  // byte index of the last byte of each little-endian header field, and the header length
  localparam logic [POS_W-1:0] HEADER_BYTES       = 18'd46;
  localparam logic [POS_W-1:0] POS_SIG_END        = 18'd3;
  localparam logic [POS_W-1:0] POS_METHOD_END     = 18'd11;
  localparam logic [POS_W-1:0] POS_CRC_END        = 18'd19;
  localparam logic [POS_W-1:0] POS_CSIZE_END      = 18'd23;
  localparam logic [POS_W-1:0] POS_USIZE_END      = 18'd27;
  localparam logic [POS_W-1:0] POS_NAMELEN_END    = 18'd29;
  localparam logic [POS_W-1:0] POS_EXTRALEN_END   = 18'd31;
  localparam logic [POS_W-1:0] POS_COMMENTLEN_END = 18'd33;
  localparam logic [POS_W-1:0] POS_HEADER_END     = 18'd45;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  name_byte;
    logic [15:0] method;
    logic [31:0] crc_value;
    logic [31:0] compressed_size;
    logic [31:0] uncompressed_size;
    logic [31:0] local_header_offset;
    logic [7:0]  name_length;
    logic        is_directory;
    logic        error_code;
    logic        last_entry;
  } result_t;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

// File: hdl/zcdp_if.sv
// handshake channels of the central directory parser
interface zcdp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface zcdp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] entry_count;
  modport source (output valid, output entry_count, input ready);
  modport sink (input valid, input entry_count, output ready);
endinterface

interface zcdp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  name_byte;
  logic [15:0] method;
  logic [31:0] crc_value;
  logic [31:0] compressed_size;
  logic [31:0] uncompressed_size;
  logic [31:0] local_header_offset;
  logic [7:0]  name_length;
  logic        is_directory;
  logic        error_code;
  logic        last_entry;
  modport source (
    output valid, output kind, output name_byte, output method, output crc_value,
    output compressed_size, output uncompressed_size, output local_header_offset,
    output name_length, output is_directory, output error_code, output last_entry,
    input ready
  );
  modport sink (
    input valid, input kind, input name_byte, input method, input crc_value,
    input compressed_size, input uncompressed_size, input local_header_offset,
    input name_length, input is_directory, input error_code, input last_entry,
    output ready
  );
endinterface

// File: hdl/zip_central_directory_parser_core.sv
// top level of the zip central directory parser
// timing: the results that a byte causes are written into the result queue when the byte is taken
// throughput: one byte per cycle while the result queue has room; the last name byte of an entry yields two
//   results, which leave the four-entry result queue one at a time
// reset: synchronous, clears the parse state, the entry count and the queue;
//   after an error the block stays halted until reset
module zip_central_directory_parser_core #(
  parameter int NAME_LIMIT = 256
) (
  input logic          clk,
  input logic          rst,
  zcdp_byte_if.sink    stream,
  zcdp_cfg_if.sink     cfg,
  zcdp_result_if.source result
);
  import zcdp_pkg::*;

  push_t   push;
  result_t res0;
  result_t res1;
  result_t head;
  logic    not_empty;
  logic    has_room;
  logic    pop;

  assign stream.ready = has_room;
  assign cfg.ready    = 1'b1;
  assign pop          = not_empty && result.ready;

  zcdp_parser #(
    .NAME_LIMIT(NAME_LIMIT)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (stream.valid && has_room),
    .data_byte (stream.data_byte),
    .cfg_write (cfg.valid),
    .cfg_value (cfg.entry_count),
    .push      (push),
    .res0      (res0),
    .res1      (res1)
  );

  zcdp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .has_room  (has_room)
  );

  assign result.valid               = not_empty;
  assign result.kind                = head.kind;
  assign result.name_byte           = head.name_byte;
  assign result.method              = head.method;
  assign result.crc_value           = head.crc_value;
  assign result.compressed_size     = head.compressed_size;
  assign result.uncompressed_size   = head.uncompressed_size;
  assign result.local_header_offset = head.local_header_offset;
  assign result.name_length         = head.name_length;
  assign result.is_directory        = head.is_directory;
  assign result.error_code          = head.error_code;
  assign result.last_entry          = head.last_entry;

endmodule

// File: hdl/zcdp_parser.sv
// header field capture and result generation, one byte per cycle while accept is high
module zcdp_parser #(
  parameter int NAME_LIMIT = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             cfg_write,
  input  logic [15:0]      cfg_value,
  output zcdp_pkg::push_t   push,
  output zcdp_pkg::result_t res0,
  output zcdp_pkg::result_t res1
);
  import zcdp_pkg::*;

  logic [POS_W-1:0] record_position, record_position_next;
  logic [15:0]      entries_left, entries_left_next;
  logic [31:0]      header_shift, header_shift_next;
  logic [15:0]      field_method, field_method_next;
  logic [31:0]      field_crc, field_crc_next;
  logic [31:0]      field_csize, field_csize_next;
  logic [31:0]      field_usize, field_usize_next;
  logic [31:0]      field_local_offset, field_local_offset_next;
  logic [15:0]      len_name, len_name_next;
  logic [15:0]      len_extra, len_extra_next;
  logic [15:0]      len_comment, len_comment_next;
  logic             last_was_slash, last_was_slash_next;
  logic             halted, halted_next;

  logic [31:0]      shift_in;
  logic             active;
  logic             stop;
  logic             name_too_long;
  logic             is_last;
  logic [POS_W-1:0] name_end;
  logic [POS_W-1:0] total;
  logic [POS_W-1:0] pos_plus;

  function automatic result_t make_record(input logic [31:0] offset, input logic slash);
    result_t r;
    r = '0;
    r.kind                = KIND_RECORD;
    r.method              = field_method;
    r.crc_value           = field_crc;
    r.compressed_size     = field_csize;
    r.uncompressed_size   = field_usize;
    r.local_header_offset = offset;
    r.name_length         = len_name[7:0];
    r.is_directory        = (len_name != 16'd0) && slash;
    r.last_entry          = is_last;
    return r;
  endfunction

  function automatic result_t make_error(input logic code);
    result_t r;
    r = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

  assign shift_in      = {data_byte, header_shift[31:8]};
  assign active        = accept && !halted && (entries_left != 16'd0);
  assign name_too_long = {1'b0, len_name} >= 17'(NAME_LIMIT);
  assign is_last       = entries_left == 16'd1;
  assign name_end      = HEADER_BYTES + POS_W'(len_name);
  assign total         = HEADER_BYTES + POS_W'(len_name) + POS_W'(len_extra)
                         + POS_W'(len_comment);
  assign pos_plus      = record_position + POS_W'(1);

  always_comb begin
    record_position_next    = record_position;
    entries_left_next       = entries_left;
    header_shift_next       = header_shift;
    field_method_next       = field_method;
    field_crc_next          = field_crc;
    field_csize_next        = field_csize;
    field_usize_next        = field_usize;
    field_local_offset_next = field_local_offset;
    len_name_next           = len_name;
    len_extra_next          = len_extra;
    len_comment_next        = len_comment;
    last_was_slash_next     = last_was_slash;
    halted_next             = halted;
    push                    = '0;
    res0                    = '0;
    res1                    = '0;
    stop                    = 1'b0;

    if (active) begin
      header_shift_next = shift_in;
      if (record_position < HEADER_BYTES) begin
        unique case (record_position)
          POS_SIG_END: begin
            if (shift_in != CD_SIGNATURE) begin
              res0        = make_error(ERR_SIGNATURE);
              push.first  = 1'b1;
              halted_next = 1'b1;
              stop        = 1'b1;
            end
          end
          POS_METHOD_END:     field_method_next = shift_in[31:16];
          POS_CRC_END:        field_crc_next    = shift_in;
          POS_CSIZE_END:      field_csize_next  = shift_in;
          POS_USIZE_END:      field_usize_next  = shift_in;
          POS_NAMELEN_END:    len_name_next     = shift_in[31:16];
          POS_EXTRALEN_END:   len_extra_next    = shift_in[31:16];
          POS_COMMENTLEN_END: len_comment_next  = shift_in[31:16];
          POS_HEADER_END: begin
            field_local_offset_next = shift_in;
            if (name_too_long) begin
              res0        = make_error(ERR_NAME_LONG);
              push.first  = 1'b1;
              halted_next = 1'b1;
              stop        = 1'b1;
            end else begin
              last_was_slash_next = 1'b0;
              // empty name: the record follows the header directly
              if (len_name == 16'd0) begin
                res0       = make_record(shift_in, 1'b0);
                push.first = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end else if (record_position < name_end) begin
        res0.kind           = KIND_NAME;
        res0.name_byte      = data_byte;
        push.first          = 1'b1;
        last_was_slash_next = data_byte == SLASH_BYTE;
        if (pos_plus == name_end) begin
          res1        = make_record(field_local_offset, data_byte == SLASH_BYTE);
          push.second = 1'b1;
        end
      end

      if (!stop) begin
        if (record_position >= POS_HEADER_END && pos_plus >= total) begin
          record_position_next = '0;
          entries_left_next    = entries_left - 16'd1;
        end else begin
          record_position_next = pos_plus;
        end
      end
    end

    if (cfg_write) begin
      entries_left_next    = cfg_value;
      record_position_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_position    <= '0;
      entries_left       <= '0;
      header_shift       <= '0;
      field_method       <= '0;
      field_crc          <= '0;
      field_csize        <= '0;
      field_usize        <= '0;
      field_local_offset <= '0;
      len_name           <= '0;
      len_extra          <= '0;
      len_comment        <= '0;
      last_was_slash     <= 1'b0;
      halted             <= 1'b0;
    end else begin
      record_position    <= record_position_next;
      entries_left       <= entries_left_next;
      header_shift       <= header_shift_next;
      field_method       <= field_method_next;
      field_crc          <= field_crc_next;
      field_csize        <= field_csize_next;
      field_usize        <= field_usize_next;
      field_local_offset <= field_local_offset_next;
      len_name           <= len_name_next;
      len_extra          <= len_extra_next;
      len_comment        <= len_comment_next;
      last_was_slash     <= last_was_slash_next;
      halted             <= halted_next;
    end
  end

endmodule

// File: hdl/zcdp_out_fifo.sv
// result queue taking up to two items per cycle and giving one
`include "zip_central_directory_parser_core_macros.svh"
module zcdp_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  zcdp_pkg::push_t   push,
  input  zcdp_pkg::result_t res0,
  input  zcdp_pkg::result_t res1,
  input  logic              pop,
  output zcdp_pkg::result_t head,
  output logic              not_empty,
  output logic              has_room
);
  import zcdp_pkg::*;

  localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(FIFO_DEPTH - 2);

  result_t            slots [FIFO_DEPTH];
  logic [PTR_W-1:0]   rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0]   wr_ptr, wr_ptr_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [PTR_W-1:0]   wr_ptr_plus;

  assign wr_ptr_plus = wr_ptr + PTR_W'(1);
  assign head        = slots[rd_ptr];
  assign not_empty   = count != '0;
  // room for the worst case of two results from one item
  assign has_room    = count <= ROOM_LIMIT;

  always_comb begin
    wr_ptr_next = wr_ptr + PTR_W'(push.first) + PTR_W'(push.second);
    rd_ptr_next = rd_ptr + PTR_W'(pop);
    count_next  = count + CNT_W'(push.first) + CNT_W'(push.second) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      slots[wr_ptr] <= res0;
    end
    if (push.second) begin
      slots[wr_ptr_plus] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
    end
  end

  `ZCDP_ASSERT(a_count_bound, count <= CNT_W'(FIFO_DEPTH))
  `ZCDP_ASSERT_IMPL(a_push_has_room, push.first, count <= ROOM_LIMIT)
  `ZCDP_ASSERT_IMPL(a_second_needs_first, push.second, push.first)
  `ZCDP_ASSERT_NEXT(a_pop_drains, pop && !push.first, count == $past(count) - CNT_W'(1))

endmodule
